@@ rtl/core/cfv_pkg.sv @@
// ----------------------------------------------------------------------------
// cfv_pkg
// Shared types and constants for the car-following vehicle step block.
// ----------------------------------------------------------------------------
package cfv_pkg;

  // Reset values of the configuration registers.
  localparam logic [30:0] RST_MAX_SPEED     = 31'd1087898;
  localparam logic [30:0] RST_MAX_ACCEL     = 31'd94372;
  localparam logic [30:0] RST_MAX_DECEL     = 31'd302121;
  localparam logic [30:0] RST_MIN_GAP       = 31'd262144;
  localparam logic [16:0] RST_TIME_STEP     = 17'd1092;
  localparam logic [16:0] RST_SLOW_FACTOR   = 17'd26214;
  localparam logic [15:0] RST_SLOW_DISTANCE = 16'd50;
  localparam logic [15:0] RST_STOP_DISTANCE = 16'd15;

  // Width of the shared divider and of the square root radicand.
  localparam int DIV_W  = 64;
  localparam int SQRT_W = 64;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MAX_SPEED,
    REG_MAX_ACCEL,
    REG_MAX_DECEL,
    REG_MIN_GAP,
    REG_TIME_STEP,
    REG_SLOW_FACTOR,
    REG_SLOW_DISTANCE,
    REG_STOP_DISTANCE
  } reg_idx_t;

  localparam logic       CMD_LOAD    = 1'b0;
  localparam logic [1:0] COLOR_GREEN = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd2;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_DV, ST_BRANCH, ST_ADV_DIV, ST_ADV_WAIT,
    ST_PM1, ST_PM2, ST_PFIN, ST_ACC, ST_SD_DIV, ST_SD_WAIT,
    ST_RMUL, ST_SQRT, ST_SQRT_WAIT, ST_TERM_WAIT, ST_NUM, ST_GAP,
    ST_DELTA_WAIT, ST_R_DIV, ST_R_WAIT, ST_R1, ST_R2, ST_DD, ST_F,
    ST_P1, ST_P2, ST_AP, ST_FINISH
  } state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [5:0] {
    OP_NONE, OP_CAPTURE, OP_LOADST, OP_VMAX, OP_DV, OP_ADV_SQ, OP_ADV_DIV,
    OP_ADV_FIN, OP_SPEED, OP_PM1, OP_PM2, OP_PFIN, OP_ACC_ZERO, OP_SD_MUL,
    OP_SD_DIV, OP_SD_FIN, OP_LEAD, OP_RMUL, OP_SQRT, OP_TERM_CAP,
    OP_TERM_DIV, OP_TERM_FIN, OP_NUM, OP_DELTA_CAP, OP_DELTA_DIV,
    OP_DELTA_FIN, OP_DELTA_ZERO, OP_R_ZERO, OP_R_DIV, OP_R_FIN, OP_R_SQ,
    OP_DD, OP_F, OP_P1, OP_P2, OP_AP, OP_OUT
  } op_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_load;
    logic neg_speed;
    logic stop_win;
    logic vmax_zero;
    logic has_leader;
    logic root_zero;
    logic gap_le0;
    logic div_busy;
    logic sqrt_busy;
  } sts_t;

endpackage

@@ rtl/core/cfv_div.sv @@
// ----------------------------------------------------------------------------
// cfv_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfv_div import cfv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quot_r, rem_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DIV_W:0]   rem_sh, diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r, quot_r[DIV_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
    diff   = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CNT_W'(DIV_W - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      den_r  <= divisor;
      cnt_r  <= '0;
    end else if (busy_r) begin
      quot_r <= {quot_r[DIV_W-2:0], ge};
      rem_r  <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

@@ rtl/core/cfv_sqrt.sv @@
// ----------------------------------------------------------------------------
// cfv_sqrt
// Integer square root, floor result, one root bit per cycle.
// ----------------------------------------------------------------------------
module cfv_sqrt import cfv_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SQRT_W-1:0]   radicand,
  output logic                busy,
  output logic [SQRT_W/2-1:0] root
);

  localparam int RW    = SQRT_W / 2;
  localparam int CNT_W = $clog2(RW);

  logic [SQRT_W-1:0] rad_r;
  logic [RW+1:0]     rem_r;
  logic [RW-1:0]     root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [RW+3:0]     rem_sh, trial, diff;
  logic              ge;

  always_comb begin
    rem_sh = {rem_r, rad_r[SQRT_W-1:SQRT_W-2]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CNT_W'(RW - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQRT_W-3:0], 2'b00};
      rem_r  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
      root_r <= {root_r[RW-2:0], ge};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

@@ rtl/core/cfv_dp.sv @@
// ----------------------------------------------------------------------------
// cfv_dp
// Datapath: configuration, vehicle state, working registers, one shared
// multiplier, the divider and the square root unit.
// ----------------------------------------------------------------------------
module cfv_dp import cfv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_wdata,
  input  logic [207:0] in_tdata,
  input  logic         in_tuser,
  output logic [95:0]  out_tdata,
  input  op_t          op,
  output sts_t         sts
);

  localparam logic [40:0] TERM_CAP  = 41'h100_0000_0000;
  localparam logic [30:0] DELTA_CAP = 31'h7FFF_FFFF;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] x);
    logic signed [31:0] r;
    if (x > 44'sh0007FFFFFFF)       r = 32'sh7FFF_FFFF;
    else if (x < -44'sh00080000000) r = 32'sh8000_0000;
    else                            r = x[31:0];
    return r;
  endfunction

  // Configuration.
  logic [30:0] max_speed_r, max_accel_r, max_decel_r, min_gap_r;
  logic [16:0] time_step_r, slow_factor_r;
  logic [15:0] slow_dist_r, stop_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r   <= RST_MAX_SPEED;
      max_accel_r   <= RST_MAX_ACCEL;
      max_decel_r   <= RST_MAX_DECEL;
      min_gap_r     <= RST_MIN_GAP;
      time_step_r   <= RST_TIME_STEP;
      slow_factor_r <= RST_SLOW_FACTOR;
      slow_dist_r   <= RST_SLOW_DISTANCE;
      stop_dist_r   <= RST_STOP_DISTANCE;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MAX_SPEED:     max_speed_r   <= cfg_wdata;
        REG_MAX_ACCEL:     max_accel_r   <= cfg_wdata;
        REG_MAX_DECEL:     max_decel_r   <= cfg_wdata;
        REG_MIN_GAP:       min_gap_r     <= cfg_wdata;
        REG_TIME_STEP:     time_step_r   <= cfg_wdata[16:0];
        REG_SLOW_FACTOR:   slow_factor_r <= cfg_wdata[16:0];
        REG_SLOW_DISTANCE: slow_dist_r   <= cfg_wdata[15:0];
        REG_STOP_DISTANCE: stop_dist_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic        cmd_r, hl_r, lpres_r;
  logic [31:0] ldpos_r, ldacc_r, lpos_r;
  logic [30:0] ldspd_r, lspd_r;
  logic [7:0]  llen_r;
  logic [1:0]  lcol_r;
  logic [15:0] lightpos_r, lanelen_r;

  // Vehicle state and working registers.
  logic signed [31:0] pos_r, acc_r;
  logic [31:0]        spd_r, vmax_r;
  logic [32:0]        dvm_r, a_r;
  logic               dvn_r, sdn_r;
  logic [33:0]        b_r;
  logic [63:0]        t_r, sq_in_r, p1_r;
  logic signed [33:0] gap_r;
  logic [40:0]        term_r;
  logic [41:0]        num_r;
  logic [30:0]        dl_r, p2_r;
  logic [16:0]        r_r;
  logic [45:0]        dd_r;
  logic signed [47:0] f_r;
  logic [95:0]        out_r;

  // Divider and square root interface.
  logic                div_start, sqrt_start, div_busy, sqrt_busy;
  logic [DIV_W-1:0]    div_a, div_b, div_q;
  logic [SQRT_W/2-1:0] sq_root;

  // Light windows, evaluated against the current position register.
  logic signed [33:0] lp_q, pos_e, lead_e, d, slow_d, stop_d;
  logic               blocked, gate, win_slow, win_stop;

  always_comb begin
    lp_q     = signed'({2'b00, lightpos_r, 16'h0000});
    pos_e    = 34'(pos_r);
    lead_e   = 34'(signed'(lpos_r));
    d        = lp_q - pos_e;
    slow_d   = signed'({2'b00, slow_dist_r, 16'h0000});
    stop_d   = signed'({2'b00, stop_dist_r, 16'h0000});
    blocked  = hl_r && (lead_e < lp_q);
    gate     = lpres_r && (lcol_r != COLOR_GREEN) && !blocked;
    win_slow = gate && (d < slow_d) && (d > stop_d);
    win_stop = gate && (d < stop_d) && (lcol_r == COLOR_RED);
  end

  // Derived values.
  logic [31:0]        acc_mag, sd_mag;
  logic signed [32:0] sdiff;
  logic signed [34:0] spd_sum;
  logic signed [42:0] s_val;
  logic [46:0]        f_mag;
  logic [63:0]        p_sum;
  logic [32:0]        ap;
  logic [33:0]        half_b;
  logic signed [43:0] pfin_sum, adv_sum;
  logic [40:0]        adv;

  always_comb begin
    acc_mag  = acc_r[31] ? (32'd0 - acc_r) : acc_r;
    sdiff    = signed'({1'b0, spd_r}) - signed'({2'b00, lspd_r});
    sd_mag   = sdiff[32] ? 32'(-sdiff) : sdiff[31:0];
    spd_sum  = signed'({3'b000, spd_r})
             + (dvn_r ? -signed'({2'b00, dvm_r}) : signed'({2'b00, dvm_r}));
    s_val    = signed'({11'd0, spd_r})
             + (sdn_r ? -signed'({2'b00, term_r}) : signed'({2'b00, term_r}));
    f_mag    = f_r[47] ? 47'(-f_r) : f_r[46:0];
    p_sum    = p1_r + {33'd0, p2_r};
    ap       = (p_sum > 64'h1_0000_0000) ? 33'h1_0000_0000 : p_sum[32:0];
    half_b   = b_r >> 1;
    pfin_sum = 44'(pos_r) + signed'({11'd0, a_r})
             + (dvn_r ? -signed'({10'd0, half_b}) : signed'({10'd0, half_b}));
    adv      = (div_q > 64'(TERM_CAP)) ? TERM_CAP : div_q[40:0];
    adv_sum  = 44'(pos_r) + signed'({3'b000, adv});
  end

  // Shared multiplier.
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_VMAX:   begin mul_a = 33'(slow_factor_r); mul_b = 32'(max_speed_r); end
      OP_DV:     begin mul_a = 33'(acc_mag);       mul_b = 32'(time_step_r); end
      OP_ADV_SQ: begin mul_a = 33'(spd_r);         mul_b = spd_r;            end
      OP_PM1:    begin mul_a = 33'(spd_r);         mul_b = 32'(time_step_r); end
      OP_PM2:    begin mul_a = dvm_r;              mul_b = 32'(time_step_r); end
      OP_SD_MUL: begin mul_a = 33'(max_decel_r);   mul_b = spd_r;            end
      OP_LEAD:   begin mul_a = 33'(spd_r);         mul_b = sd_mag;           end
      OP_RMUL:   begin mul_a = 33'(max_accel_r);   mul_b = 32'(max_decel_r); end
      OP_R_SQ:   begin mul_a = 33'(r_r);           mul_b = 32'(r_r);         end
      OP_DD:     begin mul_a = 33'(dl_r);          mul_b = 32'(dl_r);        end
      OP_P1:     begin mul_a = 33'(max_accel_r);   mul_b = 32'(f_mag[46:16]); end
      OP_P2:     begin mul_a = 33'(max_accel_r);   mul_b = 32'(f_mag[15:0]); end
      default: ;
    endcase
    mul_p = 65'(mul_a) * 65'(mul_b);
  end

  // Divider and square root.
  always_comb begin
    div_start = 1'b1;
    div_a     = t_r;
    div_b     = '0;
    case (op)
      OP_ADV_DIV:   div_b = {31'd0, acc_mag, 1'b0};
      OP_SD_DIV:    div_b = {32'd0, vmax_r};
      OP_TERM_DIV:  div_b = {31'd0, sq_root, 1'b0};
      OP_DELTA_DIV: begin
        div_a = {6'd0, num_r, 16'h0000};
        div_b = {30'd0, gap_r};
      end
      OP_R_DIV: begin
        div_a = {16'd0, spd_r, 16'h0000};
        div_b = {32'd0, vmax_r};
      end
      default: div_start = 1'b0;
    endcase
    sqrt_start = (op == OP_SQRT);
  end

  cfv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quot     (div_q)
  );

  cfv_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sq_in_r),
    .busy     (sqrt_busy),
    .root     (sq_root)
  );

  // Vehicle state: cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      spd_r <= '0;
      acc_r <= '0;
    end else begin
      case (op)
        OP_LOADST: begin
          pos_r <= ldpos_r;
          spd_r <= {1'b0, ldspd_r};
          acc_r <= ldacc_r;
        end
        OP_ADV_FIN: begin
          pos_r <= sat32(adv_sum);
          spd_r <= '0;
        end
        OP_SPEED: spd_r <= (spd_sum > signed'({3'b000, vmax_r})) ? vmax_r : spd_sum[31:0];
        OP_PFIN:   pos_r <= sat32(pfin_sum);
        OP_ACC_ZERO: acc_r <= '0;
        OP_SD_FIN: acc_r <= 32'd0 - div_q[31:0];
        OP_AP: begin
          if (f_r[47]) acc_r <= ap[32:31] != 2'b00 ? 32'h8000_0000 : 32'd0 - ap[31:0];
          else         acc_r <= ap[32:31] != 2'b00 ? 32'h7FFF_FFFF : ap[31:0];
        end
        default: ;
      endcase
    end
  end

  // Working and captured registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_CAPTURE: begin
        cmd_r      <= in_tuser;
        ldpos_r    <= in_tdata[31:0];
        ldspd_r    <= in_tdata[62:32];
        ldacc_r    <= in_tdata[94:63];
        hl_r       <= in_tdata[95];
        lpos_r     <= in_tdata[127:96];
        lspd_r     <= in_tdata[158:128];
        llen_r     <= in_tdata[166:159];
        lpres_r    <= in_tdata[167];
        lcol_r     <= in_tdata[169:168];
        lightpos_r <= in_tdata[185:170];
        lanelen_r  <= in_tdata[201:186];
      end
      OP_VMAX: vmax_r <= (win_slow || win_stop) ? mul_p[47:16] : {1'b0, max_speed_r};
      OP_DV: begin
        dvm_r <= mul_p[48:16];
        dvn_r <= acc_r[31];
      end
      OP_ADV_SQ, OP_SD_MUL: t_r <= mul_p[63:0];
      OP_PM1: a_r <= mul_p[48:16];
      OP_PM2: b_r <= mul_p[49:16];
      OP_LEAD: begin
        t_r   <= mul_p[63:0];
        sdn_r <= sdiff[32];
        gap_r <= lead_e - pos_e - signed'({10'd0, llen_r, 16'h0000});
      end
      OP_RMUL:      sq_in_r <= mul_p[63:0];
      OP_TERM_CAP:  term_r  <= (t_r != 64'd0) ? TERM_CAP : '0;
      OP_TERM_FIN:  term_r  <= (div_q > 64'(TERM_CAP)) ? TERM_CAP : div_q[40:0];
      OP_NUM:       num_r   <= 42'(min_gap_r) + (s_val > 0 ? s_val[41:0] : 42'd0);
      OP_DELTA_CAP: dl_r    <= DELTA_CAP;
      OP_DELTA_FIN: dl_r    <= (div_q > 64'(DELTA_CAP)) ? DELTA_CAP : div_q[30:0];
      OP_DELTA_ZERO: dl_r   <= '0;
      OP_R_ZERO:    r_r     <= '0;
      OP_R_FIN:     r_r     <= (div_q > 64'h1_0000) ? 17'h1_0000 : div_q[16:0];
      OP_R_SQ:      r_r     <= mul_p[32:16];
      OP_DD:        dd_r    <= mul_p[61:16];
      OP_F:         f_r     <= 48'sh1_0000 - signed'({31'd0, r_r}) - signed'({2'b00, dd_r});
      OP_P1:        p1_r    <= mul_p[63:0];
      OP_P2:        p2_r    <= mul_p[46:16];
      OP_OUT: out_r <= {(pos_e <= signed'({2'b00, lanelen_r, 16'h0000})),
                        acc_r, spd_r[30:0], pos_r};
      default: ;
    endcase
  end

  always_comb begin
    sts.is_load    = (cmd_r == CMD_LOAD);
    sts.neg_speed  = dvn_r && (dvm_r > {1'b0, spd_r});
    sts.stop_win   = win_stop;
    sts.vmax_zero  = (vmax_r == 32'd0);
    sts.has_leader = hl_r;
    sts.root_zero  = (sq_root == '0);
    sts.gap_le0    = (gap_r <= 0);
    sts.div_busy   = div_busy;
    sts.sqrt_busy  = sqrt_busy;
  end

  assign out_tdata = out_r;

endmodule

@@ rtl/core/cfv_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfv_ctrl
// Sequencer for one vehicle step; owns the stream handshakes.
// ----------------------------------------------------------------------------
module cfv_ctrl import cfv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output op_t  op
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op            = OP_NONE;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op = OP_CAPTURE; state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_load) begin
          op = OP_LOADST; state_nxt = ST_FINISH;
        end else begin
          op = OP_VMAX; state_nxt = ST_DV;
        end
      end
      ST_DV: begin op = OP_DV; state_nxt = ST_BRANCH; end
      ST_BRANCH: begin
        if (sts.neg_speed) begin
          op = OP_ADV_SQ; state_nxt = ST_ADV_DIV;
        end else begin
          op = OP_SPEED; state_nxt = ST_PM1;
        end
      end
      ST_ADV_DIV: begin op = OP_ADV_DIV; state_nxt = ST_ADV_WAIT; end
      ST_ADV_WAIT: begin
        if (!sts.div_busy) begin
          op = OP_ADV_FIN; state_nxt = ST_ACC;
        end
      end
      ST_PM1:  begin op = OP_PM1;  state_nxt = ST_PM2;  end
      ST_PM2:  begin op = OP_PM2;  state_nxt = ST_PFIN; end
      ST_PFIN: begin op = OP_PFIN; state_nxt = ST_ACC;  end
      ST_ACC: begin
        if (sts.stop_win) begin
          if (sts.vmax_zero) begin
            op = OP_ACC_ZERO; state_nxt = ST_FINISH;
          end else begin
            op = OP_SD_MUL; state_nxt = ST_SD_DIV;
          end
        end else if (sts.has_leader) begin
          op = OP_LEAD; state_nxt = ST_RMUL;
        end else begin
          op = OP_DELTA_ZERO; state_nxt = ST_R_DIV;
        end
      end
      ST_SD_DIV: begin op = OP_SD_DIV; state_nxt = ST_SD_WAIT; end
      ST_SD_WAIT: begin
        if (!sts.div_busy) begin
          op = OP_SD_FIN; state_nxt = ST_FINISH;
        end
      end
      ST_RMUL: begin op = OP_RMUL; state_nxt = ST_SQRT; end
      ST_SQRT: begin op = OP_SQRT; state_nxt = ST_SQRT_WAIT; end
      ST_SQRT_WAIT: begin
        if (!sts.sqrt_busy) begin
          if (sts.root_zero) begin
            op = OP_TERM_CAP; state_nxt = ST_NUM;
          end else begin
            op = OP_TERM_DIV; state_nxt = ST_TERM_WAIT;
          end
        end
      end
      ST_TERM_WAIT: begin
        if (!sts.div_busy) begin
          op = OP_TERM_FIN; state_nxt = ST_NUM;
        end
      end
      ST_NUM: begin op = OP_NUM; state_nxt = ST_GAP; end
      ST_GAP: begin
        if (sts.gap_le0) begin
          op = OP_DELTA_CAP; state_nxt = ST_R_DIV;
        end else begin
          op = OP_DELTA_DIV; state_nxt = ST_DELTA_WAIT;
        end
      end
      ST_DELTA_WAIT: begin
        if (!sts.div_busy) begin
          op = OP_DELTA_FIN; state_nxt = ST_R_DIV;
        end
      end
      ST_R_DIV: begin
        if (sts.vmax_zero) begin
          op = OP_R_ZERO; state_nxt = ST_R1;
        end else begin
          op = OP_R_DIV; state_nxt = ST_R_WAIT;
        end
      end
      ST_R_WAIT: begin
        if (!sts.div_busy) begin
          op = OP_R_FIN; state_nxt = ST_R1;
        end
      end
      ST_R1: begin op = OP_R_SQ; state_nxt = ST_R2; end
      ST_R2: begin op = OP_R_SQ; state_nxt = ST_DD; end
      ST_DD: begin op = OP_DD;   state_nxt = ST_F;  end
      ST_F:  begin op = OP_F;    state_nxt = ST_P1; end
      ST_P1: begin op = OP_P1;   state_nxt = ST_P2; end
      ST_P2: begin op = OP_P2;   state_nxt = ST_AP; end
      ST_AP: begin op = OP_AP;   state_nxt = ST_FINISH; end
      ST_FINISH: begin
        // Hold the finished result until the output register is free.
        if (!out_valid_r || out_tready) begin
          op = OP_OUT; out_valid_nxt = 1'b1; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DECODE))
    else $error("accepted transaction did not start a step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_valid_r && !out_tready) |=>
    (state_r == ST_FINISH && out_valid_r))
    else $error("pending result overwritten");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_ADV_DIV || op == OP_SD_DIV || op == OP_TERM_DIV ||
     op == OP_DELTA_DIV || op == OP_R_DIV) |-> !sts.div_busy)
    else $error("divider started while busy");

  a_sqrt_free: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_SQRT) |-> !sts.sqrt_busy)
    else $error("square root started while busy");

endmodule

@@ rtl/core/car_following_vehicle_step.sv @@
// ----------------------------------------------------------------------------
// car_following_vehicle_step
// One intelligent-driver-model step of a single vehicle in Q16.16.
// ----------------------------------------------------------------------------
// A load transaction copies the captured state and gives it as its result.
// The duration of a step is set by the shared divider (up to four quotients
// per step) and by the square root when a leader is present. A new
// transaction is taken only after the last result has gone to the output
// register; a waiting result only stalls the next one when it reaches its
// output stage.
// Reset (rst_n low, synchronous) clears position, speed, acceleration and
// the controller, and loads the default configuration.
module car_following_vehicle_step import cfv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_wdata,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, from bit 0: load_position, load_speed, load_accel, has_leader,
  // leader_position, leader_speed, leader_length, light_present, light_color,
  // light_position, lane_length, zero fill.
  input  logic [207:0] in_tdata,
  // in_tuser: command (0 load, 1 step).
  input  logic         in_tuser,
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, from bit 0: new_position, new_speed, new_accel, on_lane.
  output logic [95:0]  out_tdata
);

  op_t  op;
  sts_t sts;

  // The controller sequences the step; the datapath holds all arithmetic.
  cfv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .op         (op)
  );

  cfv_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .op        (op),
    .sts       (sts)
  );

endmodule
